>>> rtl/core/stepper_gate_homing_positioner_top_defines.svh
// ---------------------------------------------------------------------------
// Stepper gate positioner assertion macros
// Shared assertion templates for the gate positioner RTL.
// ---------------------------------------------------------------------------
`ifndef STEPPER_GATE_HOMING_POSITIONER_TOP_DEFINES_SVH
`define STEPPER_GATE_HOMING_POSITIONER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SGHP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SGHP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sghp_pkg.sv
// ---------------------------------------------------------------------------
// Gate positioner package
// Widths, codes, constants and payload types shared by the positioner RTL.
// ---------------------------------------------------------------------------
package sghp_pkg;

  localparam int PosW   = 14;
  localparam int MsW    = 16;
  localparam int RateW  = 14;
  localparam int SppW   = 8;
  localparam int HlimW  = 16;
  localparam int MinW   = 7;
  localparam int StepW  = 15;
  localparam int StatW  = 3;
  localparam int ProdW  = RateW + MsW;   // rate times elapsed time
  localparam int CntW   = PosW + SppW;   // magnitude times steps per percent

  localparam logic [PosW-1:0]  FULL_SCALE = 14'd10000;
  localparam logic [StepW-1:0] STEP_SAT   = 15'd32767;
  localparam logic [ProdW-1:0] SLEW_SAT   = 30'd10000000;

  // floor(x / 125) = (x * RECIP_125) >> 28 for x below 2**21.
  localparam logic [21:0] RECIP_125 = 22'd2147484;
  // floor(y / 25) = (y * RECIP_25) >> 25 for y below 2**20.
  localparam logic [20:0] RECIP_25  = 21'd1342178;

  localparam logic CMD_SERVICE = 1'b0;
  localparam logic CMD_HOMING  = 1'b1;

  localparam logic [StatW-1:0] ST_NO_MOVE        = 3'd0;
  localparam logic [StatW-1:0] ST_MOVING         = 3'd1;
  localparam logic [StatW-1:0] ST_OPEN_REFUSED   = 3'd2;
  localparam logic [StatW-1:0] ST_CLOSED_REFUSED = 3'd3;
  localparam logic [StatW-1:0] ST_HOMING         = 3'd4;
  localparam logic [StatW-1:0] ST_HOMED          = 3'd5;
  localparam logic [StatW-1:0] ST_JAMMED         = 3'd6;
  localparam logic [StatW-1:0] ST_NOT_READY      = 3'd7;

  localparam logic [1:0] CFG_RATE_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_STEPS_PER_PC = 2'd1;
  localparam logic [1:0] CFG_HOMING_LIMIT = 2'd2;
  localparam logic [1:0] CFG_MIN_MOVE     = 2'd3;

  typedef struct packed {
    logic            cmd;
    logic [PosW-1:0] target;
    logic [MsW-1:0]  elapsed;
    logic            closed_hit;
    logic            open_hit;
  } in_item_t;

  typedef struct packed {
    logic            cmd;
    logic [PosW-1:0] target;
    logic [PosW-1:0] slew_cap;
    logic            closed_hit;
    logic            open_hit;
  } slew_item_t;

  typedef struct packed {
    logic [PosW-1:0]  mag;
    logic [StatW-1:0] status;
    logic             dir_open;
    logic [PosW-1:0]  position;
    logic             homed;
    logic             jammed;
  } move_t;

  typedef struct packed {
    logic [StepW-1:0] step_count;
    logic             dir_open;
    logic [StatW-1:0] status;
    logic [PosW-1:0]  position;
    logic             homed;
    logic             jammed;
  } result_t;

endpackage

>>> rtl/core/stepper_gate_homing_positioner_top.sv
// ---------------------------------------------------------------------------
// Stepper gate homing positioner
// Homing and slew-rate-limited positioning of a stepper-driven gate.
// ---------------------------------------------------------------------------
// The block takes one transaction per clock while the output side is not
// stalled and returns exactly one result transaction for each, in order,
// through a six-register pipeline: input register, rate-times-time product,
// division by 1000 with clamp, the control stage that owns position, homing
// and jam state, step-count product, and division by 100 into the output
// register. Only the control stage reads and writes state, and it finishes
// one item per cycle, so throughput is one item per clock while the output
// is not stalled. Empty stages keep filling while the output is stalled,
// so up to six transactions may be in flight. Configuration is written
// through the cfg port, which is always ready, and must only be written
// while no transaction is in flight. There is no clearing pass after reset.
module stepper_gate_homing_positioner_top
  import sghp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // [13:0] target_pos, [29:14] elapsed_ms, [30] closed_switch_hit,
  // [31] open_switch_hit.
  input  logic [31:0] in_tdata,
  // [0] command.
  input  logic [0:0]  in_tuser,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [14:0] step_count, [15] direction_open, [29:16] position, [30] homed,
  // [31] jammed.
  output logic [31:0] out_tdata,
  // [2:0] status.
  output logic [2:0]  out_tuser,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

`include "stepper_gate_homing_positioner_top_defines.svh"

  // Configuration registers.
  logic [RateW-1:0] rate_limit_r;
  logic [SppW-1:0]  steps_per_pc_r;
  logic [HlimW-1:0] homing_step_limit_r;
  logic [MinW-1:0]  min_move_r;

  // Stage valid bits; stage 5 is the output register.
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en0, en1, en2, en3, en4, en5;

  in_item_t   in_item;
  in_item_t   s0_r;
  slew_item_t slew_item;
  move_t      move_item;
  result_t    result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_limit_r        <= 14'd400;
      steps_per_pc_r      <= 8'd18;
      homing_step_limit_r <= 16'd4000;
      min_move_r          <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RATE_LIMIT:   rate_limit_r        <= cfg_data[RateW-1:0];
        CFG_STEPS_PER_PC: steps_per_pc_r      <= cfg_data[SppW-1:0];
        CFG_HOMING_LIMIT: homing_step_limit_r <= cfg_data[HlimW-1:0];
        CFG_MIN_MOVE:     min_move_r          <= cfg_data[MinW-1:0];
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on this cycle, so
  // bubbles are squeezed out even while the output is stalled.
  assign en5 = !v5_r || out_tready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;

  assign in_tready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_tvalid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  assign in_item.cmd        = in_tuser[0];
  assign in_item.target     = in_tdata[13:0];
  assign in_item.elapsed    = in_tdata[29:14];
  assign in_item.closed_hit = in_tdata[30];
  assign in_item.open_hit   = in_tdata[31];

  always_ff @(posedge clk) begin
    if (en0) begin
      s0_r <= in_item;
    end
  end

  sghp_slew u_slew (
    .clk        (clk),
    .en1        (en1),
    .en2        (en2),
    .item_i     (s0_r),
    .rate_limit (rate_limit_r),
    .item_o     (slew_item)
  );

  // State advances only when a valid item leaves the slew stages.
  sghp_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .en3               (en3),
    .item_vld          (v2_r),
    .item_i            (slew_item),
    .homing_step_limit (homing_step_limit_r),
    .min_move          (min_move_r),
    .move_o            (move_item)
  );

  sghp_step_scale u_step_scale (
    .clk          (clk),
    .en4          (en4),
    .en5          (en5),
    .move_i       (move_item),
    .steps_per_pc (steps_per_pc_r),
    .result_o     (result)
  );

  assign out_tvalid = v5_r;
  assign out_tdata  = {result.jammed, result.homed, result.position,
                       result.dir_open, result.step_count};
  assign out_tuser  = result.status;

  // The tracked position never leaves the travel range.
  `SGHP_ASSERT_IMP(a_pos_range, out_tvalid, out_tdata[29:16] <= FULL_SCALE,
                   "position beyond full scale")

  // Homing succeeds or jams, never both.
  `SGHP_ASSERT_IMP(a_homed_xor_jam, out_tvalid, !(out_tdata[30] && out_tdata[31]),
                   "homed and jammed both set")

  // Only moving and homing results carry steps or a direction.
  `SGHP_ASSERT_IMP(a_idle_zero,
                   out_tvalid && out_tuser != ST_MOVING && out_tuser != ST_HOMING,
                   out_tdata[15:0] == 16'd0,
                   "idle result carries steps")

  // A homing step is exactly one step toward closed, before homing or jam.
  `SGHP_ASSERT_IMP(a_homing_step, out_tvalid && out_tuser == ST_HOMING,
                   out_tdata[15:0] == 16'd1 && !out_tdata[30] && !out_tdata[31],
                   "malformed homing step")

  // An item leaving the control stage is never dropped.
  `SGHP_ASSERT_NXT(a_ctrl_handoff, v2_r && en3, v3_r, "item lost after control stage")

endmodule

>>> rtl/core/sghp_slew.sv
// ---------------------------------------------------------------------------
// Gate positioner slew limit stages
// Two stages: rate times elapsed time, then division by 1000 with clamp.
// ---------------------------------------------------------------------------
module sghp_slew
  import sghp_pkg::*;
(
  input  logic             clk,
  input  logic             en1,
  input  logic             en2,
  input  in_item_t         item_i,
  input  logic [RateW-1:0] rate_limit,
  output slew_item_t       item_o
);

  typedef struct packed {
    logic             cmd;
    logic [PosW-1:0]  target;
    logic [ProdW-1:0] prod;
    logic             closed_hit;
    logic             open_hit;
  } prod_item_t;

  prod_item_t s1_r;
  slew_item_t s2_r;
  logic [PosW-1:0] target_clamped;
  logic [20:0]     div8;
  logic [42:0]     quot_prod;
  logic [PosW-1:0] quot;

  assign target_clamped = (item_i.target > FULL_SCALE) ? FULL_SCALE : item_i.target;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r.cmd        <= item_i.cmd;
      s1_r.target     <= target_clamped;
      s1_r.prod       <= ProdW'(rate_limit) * ProdW'(item_i.elapsed);
      s1_r.closed_hit <= item_i.closed_hit;
      s1_r.open_hit   <= item_i.open_hit;
    end
  end

  // Below the clamp the product fits 24 bits: divide by 8, then by 125.
  assign div8      = s1_r.prod[23:3];
  assign quot_prod = 43'(div8) * 43'(RECIP_125);
  assign quot      = quot_prod[41:28];

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_r.cmd        <= s1_r.cmd;
      s2_r.target     <= s1_r.target;
      s2_r.slew_cap   <= (s1_r.prod >= SLEW_SAT) ? FULL_SCALE : quot;
      s2_r.closed_hit <= s1_r.closed_hit;
      s2_r.open_hit   <= s1_r.open_hit;
    end
  end

  assign item_o = s2_r;

endmodule

>>> rtl/core/sghp_ctrl.sv
// ---------------------------------------------------------------------------
// Gate positioner control stage
// Holds position, homing and jam state and decides each item's move.
// ---------------------------------------------------------------------------
module sghp_ctrl
  import sghp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en3,
  input  logic             item_vld,
  input  slew_item_t       item_i,
  input  logic [HlimW-1:0] homing_step_limit,
  input  logic [MinW-1:0]  min_move,
  output move_t            move_o
);

  logic [PosW-1:0]  pos_r, pos_nxt;
  logic             homed_r, homed_nxt;
  logic             jam_r, jam_nxt;
  logic [HlimW-1:0] hcnt_r, hcnt_nxt;
  move_t            move_r, move_nxt;

  logic             opening;
  logic [PosW-1:0]  diff;
  logic [PosW-1:0]  mag;
  logic [StatW-1:0] status;
  logic             upd;

  assign upd     = en3 & item_vld;
  assign opening = item_i.target > pos_r;
  assign diff    = opening ? (item_i.target - pos_r) : (pos_r - item_i.target);
  assign mag     = (diff > item_i.slew_cap) ? item_i.slew_cap : diff;

  always_comb begin
    pos_nxt   = pos_r;
    homed_nxt = homed_r;
    jam_nxt   = jam_r;
    hcnt_nxt  = hcnt_r;
    if (item_i.cmd == CMD_HOMING) begin
      priority if (jam_r) begin
        status = ST_JAMMED;
      end else if (homed_r) begin
        status = ST_HOMED;
      end else if (hcnt_r >= homing_step_limit) begin
        jam_nxt = 1'b1;
        status  = ST_JAMMED;
      end else if (item_i.closed_hit) begin
        pos_nxt   = '0;
        homed_nxt = 1'b1;
        status    = ST_HOMED;
      end else begin
        hcnt_nxt = hcnt_r + 1'b1;
        status   = ST_HOMING;
      end
    end else begin
      priority if (!homed_r || jam_r) begin
        status = ST_NOT_READY;
      end else if (mag == '0 || mag < PosW'(min_move)) begin
        status = ST_NO_MOVE;
      end else if (opening && item_i.open_hit) begin
        status = ST_OPEN_REFUSED;
      end else if (!opening && item_i.closed_hit) begin
        status = ST_CLOSED_REFUSED;
      end else begin
        status  = ST_MOVING;
        pos_nxt = opening ? (pos_r + mag) : (pos_r - mag);
      end
    end
  end

  always_comb begin
    move_nxt.mag      = mag;
    move_nxt.status   = status;
    move_nxt.dir_open = opening & (status == ST_MOVING);
    move_nxt.position = pos_nxt;
    move_nxt.homed    = homed_nxt;
    move_nxt.jammed   = jam_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      homed_r <= 1'b0;
      jam_r   <= 1'b0;
      hcnt_r  <= '0;
    end else if (upd) begin
      pos_r   <= pos_nxt;
      homed_r <= homed_nxt;
      jam_r   <= jam_nxt;
      hcnt_r  <= hcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      move_r <= move_nxt;
    end
  end

  assign move_o = move_r;

endmodule

>>> rtl/core/sghp_step_scale.sv
// ---------------------------------------------------------------------------
// Gate positioner step scaling stages
// Magnitude times steps per percent, then division by 100 with saturation.
// ---------------------------------------------------------------------------
module sghp_step_scale
  import sghp_pkg::*;
(
  input  logic            clk,
  input  logic            en4,
  input  logic            en5,
  input  move_t           move_i,
  input  logic [SppW-1:0] steps_per_pc,
  output result_t         result_o
);

  typedef struct packed {
    logic [CntW-1:0]  cnt;
    logic [StatW-1:0] status;
    logic             dir_open;
    logic [PosW-1:0]  position;
    logic             homed;
    logic             jammed;
  } cnt_item_t;

  cnt_item_t s4_r;
  result_t   res_r;
  logic [19:0]      div4;
  logic [40:0]      quot_prod;
  logic [15:0]      quot;
  logic [StepW-1:0] steps_sat;
  logic [StepW-1:0] step_count;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_r.cnt      <= CntW'(move_i.mag) * CntW'(steps_per_pc);
      s4_r.status   <= move_i.status;
      s4_r.dir_open <= move_i.dir_open;
      s4_r.position <= move_i.position;
      s4_r.homed    <= move_i.homed;
      s4_r.jammed   <= move_i.jammed;
    end
  end

  // Divide by 4, then by 25.
  assign div4      = s4_r.cnt[21:2];
  assign quot_prod = 41'(div4) * 41'(RECIP_25);
  assign quot      = quot_prod[40:25];
  assign steps_sat = (quot > 16'(STEP_SAT)) ? STEP_SAT : quot[StepW-1:0];

  always_comb begin
    if (s4_r.status == ST_MOVING) begin
      step_count = steps_sat;
    end else if (s4_r.status == ST_HOMING) begin
      step_count = StepW'(1);
    end else begin
      step_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      res_r.step_count <= step_count;
      res_r.dir_open   <= s4_r.dir_open;
      res_r.status     <= s4_r.status;
      res_r.position   <= s4_r.position;
      res_r.homed      <= s4_r.homed;
      res_r.jammed     <= s4_r.jammed;
    end
  end

  assign result_o = res_r;

endmodule

>>> sim/tb_top.sv
// ---------------------------------------------------------------------------
// Gate positioner testbench
// Drives homing and service transactions into the stepper gate positioner,
// predicts every result from its own model of the gate and compares them.
// ---------------------------------------------------------------------------
module tb_top;
  import sghp_pkg::*;

  localparam int PHASES          = 15;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int HOLD_CYCLES     = 60;
  localparam int SETTLE_CYCLES   = 2;
  localparam int DRAIN_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT  = 2000;

  // The tracker keeps its own copy of the registers and of the gate state.
  // Each accepted input transaction advances that state and queues the result
  // that the block owes; each result transaction is checked against the
  // oldest entry of that queue.
  class gate_tracker;
    logic [RateW-1:0]  rate_limit;
    logic [SppW-1:0]   steps_per_pc;
    logic [HlimW-1:0]  homing_limit;
    logic [MinW-1:0]   min_move;
    logic [PosW-1:0]   position;
    logic              homed;
    logic              jammed;
    logic [HlimW-1:0]  homing_steps;
    result_t           owed_results[$];
    int                errors;

    function new();
      rate_limit   = 14'd400;
      steps_per_pc = 8'd18;
      homing_limit = 16'd4000;
      min_move     = 7'd1;
      position     = '0;
      homed        = 1'b0;
      jammed       = 1'b0;
      homing_steps = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        CFG_RATE_LIMIT:   rate_limit   = value[RateW-1:0];
        CFG_STEPS_PER_PC: steps_per_pc = value[SppW-1:0];
        CFG_HOMING_LIMIT: homing_limit = value[HlimW-1:0];
        CFG_MIN_MOVE:     min_move     = value[MinW-1:0];
        default: ;
      endcase
    endfunction

    // Applies one command to the gate and returns the result it produces.
    function result_t advance_gate(in_item_t cmd_item);
      result_t          r;
      longint unsigned  goal;
      longint unsigned  slew;
      longint unsigned  mag;
      longint unsigned  cnt;
      bit               opening;
      r = '0;
      if (cmd_item.cmd == CMD_HOMING) begin
        // A jam is sticky and a homed gate ignores further homing. The step
        // budget is tested before the closed switch is looked at.
        if (jammed) begin
          r.status = ST_JAMMED;
        end else if (homed) begin
          r.status = ST_HOMED;
        end else if (homing_steps >= homing_limit) begin
          jammed   = 1'b1;
          r.status = ST_JAMMED;
        end else if (cmd_item.closed_hit) begin
          position = '0;
          homed    = 1'b1;
          r.status = ST_HOMED;
        end else begin
          homing_steps = homing_steps + 1'b1;
          r.step_count = StepW'(1);
          r.status     = ST_HOMING;
        end
      end else if (!homed || jammed) begin
        r.status = ST_NOT_READY;
      end else begin
        goal = (cmd_item.target > FULL_SCALE) ? FULL_SCALE : cmd_item.target;
        slew = (longint'(rate_limit) * longint'(cmd_item.elapsed)) / 1000;
        if (slew > FULL_SCALE) slew = FULL_SCALE;
        opening = goal > position;
        mag = opening ? goal - position : position - goal;
        if (mag > slew) mag = slew;
        // A zero delta is never a move, even when the minimum move is zero.
        if (mag == 0 || mag < min_move) begin
          r.status = ST_NO_MOVE;
        end else if (opening && cmd_item.open_hit) begin
          r.status = ST_OPEN_REFUSED;
        end else if (!opening && cmd_item.closed_hit) begin
          r.status = ST_CLOSED_REFUSED;
        end else begin
          cnt = (mag * steps_per_pc) / 100;
          if (cnt > STEP_SAT) cnt = STEP_SAT;
          r.step_count = StepW'(cnt);
          r.dir_open   = opening;
          position     = opening ? PosW'(position + mag) : PosW'(position - mag);
          r.status     = ST_MOVING;
        end
      end
      r.position = position;
      r.homed    = homed;
      r.jammed   = jammed;
      return r;
    endfunction

    function void take_command(in_item_t cmd_item);
      owed_results.push_back(advance_gate(cmd_item));
    endfunction

    function void check_field(string field_name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name,
                 want, got);
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d position %0d",
                 $time, got.status, got.position);
        return;
      end
      want = owed_results.pop_front();
      check_field("step_count", want.step_count, got.step_count);
      check_field("direction_open", want.dir_open, got.dir_open);
      check_field("status", want.status, got.status);
      check_field("position", want.position, got.position);
      check_field("homed", want.homed, got.homed);
      check_field("jammed", want.jammed, got.jammed);
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  gate_tracker tracker = new();
  int          quiet_cycles = 0;
  // Idling controls shared between the main sequence and the receiver.
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  bit          hold_request = 1'b0;
  bit          jam_run;

  stepper_gate_homing_positioner_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Both streams are sampled at the rising edge. The input transaction is
  // noted before the result check; with the pipeline latency a result can
  // never belong to an input taken at the same edge anyway.
  always @(posedge clk) begin
    in_item_t cmd_item;
    result_t  got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        cmd_item.cmd        = in_tuser[0];
        cmd_item.target     = in_tdata[13:0];
        cmd_item.elapsed    = in_tdata[29:14];
        cmd_item.closed_hit = in_tdata[30];
        cmd_item.open_hit   = in_tdata[31];
        tracker.take_command(cmd_item);
      end
      if (out_tvalid && out_tready) begin
        got.step_count = out_tdata[14:0];
        got.dir_open   = out_tdata[15];
        got.position   = out_tdata[29:16];
        got.homed      = out_tdata[30];
        got.jammed     = out_tdata[31];
        got.status     = out_tuser;
        tracker.match_result(got);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The run is ended if no transaction of any kind is taken for too long.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result receiver. A hold request parks out_tready low for a long stretch
  // so that the pipeline fills and the block stops taking inputs; otherwise
  // it stalls in short random bursts while stalls are enabled.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offers one command and returns at the edge where it is taken. A random
  // gap with nothing offered may come first while gaps are enabled.
  task automatic send_command(input logic cmd, input logic [PosW-1:0] target,
                              input logic [MsW-1:0] elapsed, input logic closed_hit,
                              input logic open_hit);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {open_hit, closed_hit, elapsed, target};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering commands and waits until every owed result has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers may only change with the pipeline empty.
  task automatic load_settings(input logic [15:0] rate, input logic [15:0] spp,
                               input logic [15:0] limit, input logic [15:0] min_mv);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_RATE_LIMIT, rate);
    write_reg(CFG_STEPS_PER_PC, spp);
    write_reg(CFG_HOMING_LIMIT, limit);
    write_reg(CFG_MIN_MOVE, min_mv);
  endtask

  task automatic load_random_settings();
    logic [15:0] rate;
    logic [15:0] spp;
    logic [15:0] limit;
    logic [15:0] min_mv;
    case ($urandom_range(0, 3))
      0:       rate = 16'd0;
      1:       rate = 16'd10000;
      default: rate = 16'($urandom_range(0, 10000));
    endcase
    case ($urandom_range(0, 3))
      0:       spp = 16'd1;
      1:       spp = 16'd255;
      default: spp = 16'($urandom_range(1, 255));
    endcase
    case ($urandom_range(0, 3))
      0:       limit = 16'd1;
      1:       limit = 16'd65535;
      default: limit = 16'($urandom_range(1, 65535));
    endcase
    // Small minimum moves keep most ticks moving the gate.
    case ($urandom_range(0, 5))
      0:       min_mv = 16'd0;
      1:       min_mv = 16'd100;
      default: min_mv = 16'($urandom_range(0, 20));
    endcase
    load_settings(rate, spp, limit, min_mv);
  endtask

  // Mostly service ticks aimed near the tracked position, with some jumps to
  // the ends of travel, targets above full scale and the odd homing command.
  task automatic send_random_command();
    int unsigned    goal;
    logic [MsW-1:0] ms;
    logic           closed_hit;
    logic           open_hit;
    case ($urandom_range(0, 7))
      0:       goal = $urandom_range(0, 16383);
      1:       goal = FULL_SCALE;
      2:       goal = 0;
      default: begin
        goal = tracker.position + $urandom_range(0, 600);
        goal = (goal > 300) ? goal - 300 : 0;
        if (goal > 16383) goal = 16383;
      end
    endcase
    case ($urandom_range(0, 7))
      0:       ms = MsW'($urandom_range(0, 65535));
      1:       ms = '1;
      2:       ms = '0;
      default: ms = MsW'($urandom_range(0, 2000));
    endcase
    closed_hit = ($urandom_range(0, 5) == 0);
    open_hit   = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 9) == 0) begin
      send_command(CMD_HOMING, PosW'(goal), ms, closed_hit, open_hit);
    end else begin
      send_command(CMD_SERVICE, PosW'(goal), ms, closed_hit, open_hit);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    // Homing and jam are both sticky and reset comes only once, so each run
    // takes one of the two paths; the seed picks, favoring the homed path.
    jam_run = ($urandom_range(0, 5) == 0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A service tick before homing is not ready.
    send_command(CMD_SERVICE, 14'd5000, 16'd1000, 1'b0, 1'b0);
    if (jam_run) begin
      // With a zero step budget the first homing command jams at once, even
      // with the closed switch pressed. After that the jam is sticky.
      load_settings(16'd400, 16'd18, 16'd0, 16'd1);
      send_command(CMD_HOMING, 14'd0, 16'd0, 1'b1, 1'b0);
      send_command(CMD_HOMING, 14'd0, 16'd0, 1'b0, 1'b0);
      send_command(CMD_SERVICE, 14'd10000, 16'd65535, 1'b0, 1'b0);
    end else begin
      load_settings(16'd400, 16'd18, 16'd4, 16'd1);
      repeat (3) send_command(CMD_HOMING, 14'd0, 16'd0, 1'b0, 1'b0);
      send_command(CMD_HOMING, 14'd0, 16'd0, 1'b1, 1'b0);
      // Homing once homed is ignored.
      send_command(CMD_HOMING, 14'd0, 16'd0, 1'b0, 1'b1);
      // Target above full scale with the slew clamped, then a zero delta.
      send_command(CMD_SERVICE, 14'h3FFF, 16'hFFFF, 1'b0, 1'b0);
      send_command(CMD_SERVICE, 14'h3FFF, 16'd1000, 1'b0, 1'b0);
      // No elapsed time, and a slew that truncates to zero with the switch
      // pressed: both are no move rather than a refusal.
      send_command(CMD_SERVICE, 14'd0, 16'd0, 1'b0, 1'b0);
      send_command(CMD_SERVICE, 14'd0, 16'd2, 1'b1, 1'b0);
      send_command(CMD_SERVICE, 14'd0, 16'd1000, 1'b1, 1'b0);
      send_command(CMD_SERVICE, 14'd0, 16'd1000, 1'b0, 1'b0);
      send_command(CMD_SERVICE, 14'd10000, 16'd1000, 1'b0, 1'b1);
      // A one-hundredth move truncates to zero steps but still moves.
      send_command(CMD_SERVICE, 14'd9601, 16'd3, 1'b0, 1'b0);
      load_settings(16'd10000, 16'd255, 16'd4, 16'd0);
      send_command(CMD_SERVICE, 14'd9601, 16'hFFFF, 1'b0, 1'b0);
      send_command(CMD_SERVICE, 14'd0, 16'hFFFF, 1'b0, 1'b0);
      load_settings(16'd0, 16'd1, 16'd65535, 16'd100);
      send_command(CMD_SERVICE, 14'd10000, 16'hFFFF, 1'b0, 1'b0);
      load_settings(16'd1000, 16'd1, 16'd65535, 16'd100);
      send_command(CMD_SERVICE, 14'd99, 16'hFFFF, 1'b0, 1'b0);
      send_command(CMD_SERVICE, 14'd100, 16'hFFFF, 1'b0, 1'b0);
    end

    // Random part, one register setting per phase. The last two phases run
    // without idling on either side.
    for (int phase = 0; phase < PHASES; phase++) begin
      load_random_settings();
      tx_gaps   = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
      rx_stalls = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        // Keep offering back to back while the receiver holds off.
        tx_gaps      = 1'b0;
        hold_request = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 4 && n == ITEMS_PER_PHASE / 2) drain_results();
        send_random_command();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
